### sv/arpc_pkg.sv
// Shared types and constants of the ARP responder with cache.
`timescale 1ns / 1ps
`default_nettype none
package arpc_pkg;

    // Result status codes.
    localparam logic [2:0] ST_IGNORED    = 3'd0;
    localparam logic [2:0] ST_REPLY      = 3'd1;
    localparam logic [2:0] ST_DROPPED    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN_OP = 3'd3;
    localparam logic [2:0] ST_HIT        = 3'd4;
    localparam logic [2:0] ST_MISS       = 3'd5;

    // Fixed ARP header values that a valid packet carries.
    localparam logic [15:0] HTYPE_ETH  = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  HLEN_ETH   = 8'd6;
    localparam logic [7:0]  PLEN_IPV4  = 8'd4;
    localparam logic [15:0] ARP_OP_REQ = 16'd1;
    localparam logic [15:0] ARP_OP_RSP = 16'd2;

    // Register indexes of the configuration port.
    localparam logic REG_MY_IP  = 1'b0;
    localparam logic REG_MY_MAC = 1'b1;

    // Action selector on the input side.
    localparam logic ACT_PACKET = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    // What the back end has to do with a queued item.
    typedef enum logic [1:0] {
        OPK_FIXED,   // status is already known, no cache access
        OPK_STORE,   // reply sent, learn the sender in the cache
        OPK_LOOKUP   // resolve query against the cache
    } op_kind_t;

    typedef struct packed {
        op_kind_t    op;
        logic [2:0]  status;
        logic [47:0] mac;
        logic [31:0] ip;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage
`default_nettype wire

### sv/arpc_front.sv
// Front end: takes input transfers, checks and classifies ARP packets.
`timescale 1ns / 1ps
`default_nettype none
module arpc_front (
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [207:0]         s_tdata,
    input  wire logic                 s_tuser,
    input  wire logic [31:0]          my_ip,
    input  wire arpc_pkg::queue_stat_t q_stat,
    output logic                      push,
    output arpc_pkg::item_t           item
);

    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] operation;
    logic [47:0] snd_mac;
    logic [31:0] snd_ip;
    logic [31:0] tgt_ip;
    logic [31:0] query_ip;
    logic        hdr_ok;

    assign hw_type    = s_tdata[15:0];
    assign proto_type = s_tdata[31:16];
    assign hw_len     = s_tdata[39:32];
    assign proto_len  = s_tdata[47:40];
    assign operation  = s_tdata[63:48];
    assign snd_mac    = s_tdata[111:64];
    assign snd_ip     = s_tdata[143:112];
    assign tgt_ip     = s_tdata[175:144];
    assign query_ip   = s_tdata[207:176];

    assign hdr_ok = (hw_type == arpc_pkg::HTYPE_ETH) && (proto_type == arpc_pkg::PTYPE_IPV4)
                 && (hw_len == arpc_pkg::HLEN_ETH) && (proto_len == arpc_pkg::PLEN_IPV4);

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && !q_stat.full;

    always_comb begin
        item        = '0;
        item.op     = arpc_pkg::OPK_FIXED;
        item.status = arpc_pkg::ST_IGNORED;
        if (s_tuser == arpc_pkg::ACT_QUERY) begin
            item.op = arpc_pkg::OPK_LOOKUP;
            item.ip = query_ip;
        end else if (!hdr_ok) begin
            item.status = arpc_pkg::ST_DROPPED;
        end else if (operation == arpc_pkg::ARP_OP_REQ) begin
            // Only a request for our own address is answered and learned.
            if (tgt_ip == my_ip) begin
                item.op     = arpc_pkg::OPK_STORE;
                item.status = arpc_pkg::ST_REPLY;
                item.mac    = snd_mac;
                item.ip     = snd_ip;
            end
        end else if (operation == arpc_pkg::ARP_OP_RSP) begin
            item.status = arpc_pkg::ST_IGNORED;
        end else begin
            item.status = arpc_pkg::ST_UNKNOWN_OP;
        end
    end

endmodule
`default_nettype wire

### sv/arpc_queue.sv
// Two-entry queue that decouples the front end from the cache back end.
`timescale 1ns / 1ps
`default_nettype none
module arpc_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire arpc_pkg::item_t       push_item,
    input  wire logic                  pop,
    output arpc_pkg::item_t            head_item,
    output arpc_pkg::queue_stat_t      q_stat
);

    arpc_pkg::item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign q_stat.empty = (count_reg == 2'd0);
    assign q_stat.full  = (count_reg == 2'd2);
    assign head_item    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

### sv/arpc_back.sv
// Back end: associative IP-to-MAC cache and the registered result stage.
`timescale 1ns / 1ps
`default_nettype none
module arpc_back #(
    parameter int CACHE_ENTRIES = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire arpc_pkg::queue_stat_t q_stat,
    input  wire arpc_pkg::item_t       head_item,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [127:0]               m_tdata,
    output logic [2:0]                 m_tuser
);

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    logic [CACHE_ENTRIES-1:0] entry_valid_reg;
    logic [31:0]              entry_ip_reg  [CACHE_ENTRIES];
    logic [47:0]              entry_mac_reg [CACHE_ENTRIES];
    logic [IDX_W-1:0]         replace_ptr_reg, replace_ptr_next;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [2:0]               status_reg, status_next;
    logic [47:0]              dest_mac_reg, dest_mac_next;
    logic [31:0]              dest_ip_reg, dest_ip_next;
    logic [47:0]              res_mac_reg, res_mac_next;

    logic [CACHE_ENTRIES-1:0] match;
    logic                     match_any, free_any, do_store;
    logic [IDX_W-1:0]         match_idx, free_idx, slot;
    logic [47:0]              hit_mac;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {res_mac_reg, dest_ip_reg, dest_mac_reg};

    // The result stage takes a new item whenever it is empty or being drained.
    assign pop = !q_stat.empty && (!m_tvalid_reg || m_tready);

    // Parallel compare of all valid entries; cached IPs are unique.
    always_comb begin
        match     = '0;
        hit_mac   = '0;
        match_idx = '0;
        free_idx  = '0;
        free_any  = 1'b0;
        for (int k = CACHE_ENTRIES - 1; k >= 0; k--) begin
            match[k] = entry_valid_reg[k] && (entry_ip_reg[k] == head_item.ip);
            if (match[k]) begin
                match_idx = IDX_W'(k);
            end
            if (!entry_valid_reg[k]) begin
                free_idx = IDX_W'(k);
                free_any = 1'b1;
            end
        end
        for (int k = 0; k < CACHE_ENTRIES; k++) begin
            hit_mac = hit_mac | (match[k] ? entry_mac_reg[k] : 48'd0);
        end
        match_any = |match;
    end

    always_comb begin
        do_store         = pop && (head_item.op == arpc_pkg::OPK_STORE);
        replace_ptr_next = replace_ptr_reg;
        if (match_any) begin
            slot = match_idx;
        end else if (free_any) begin
            slot = free_idx;
        end else begin
            slot = replace_ptr_reg;
            if (do_store) begin
                replace_ptr_next = (replace_ptr_reg == LAST_IDX) ? '0
                                                                 : replace_ptr_reg + 1'b1;
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        status_next   = status_reg;
        dest_mac_next = dest_mac_reg;
        dest_ip_next  = dest_ip_reg;
        res_mac_next  = res_mac_reg;
        if (pop) begin
            m_tvalid_next = 1'b1;
            status_next   = head_item.status;
            dest_mac_next = '0;
            dest_ip_next  = '0;
            res_mac_next  = '0;
            case (head_item.op)
                arpc_pkg::OPK_STORE: begin
                    status_next   = arpc_pkg::ST_REPLY;
                    dest_mac_next = head_item.mac;
                    dest_ip_next  = head_item.ip;
                end
                arpc_pkg::OPK_LOOKUP: begin
                    status_next  = match_any ? arpc_pkg::ST_HIT : arpc_pkg::ST_MISS;
                    res_mac_next = hit_mac;
                end
                default: begin
                    status_next = head_item.status;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        status_reg   <= status_next;
        dest_mac_reg <= dest_mac_next;
        dest_ip_reg  <= dest_ip_next;
        res_mac_reg  <= res_mac_next;
        for (int k = 0; k < CACHE_ENTRIES; k++) begin
            if (do_store && (slot == IDX_W'(k))) begin
                entry_ip_reg[k]  <= head_item.ip;
                entry_mac_reg[k] <= head_item.mac;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg    <= 1'b0;
            entry_valid_reg <= '0;
            replace_ptr_reg <= '0;
        end else begin
            m_tvalid_reg    <= m_tvalid_next;
            replace_ptr_reg <= replace_ptr_next;
            for (int k = 0; k < CACHE_ENTRIES; k++) begin
                if (do_store && (slot == IDX_W'(k))) begin
                    entry_valid_reg[k] <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

### sv/arp_responder_with_cache_top.sv
// Top level of the ARP responder with an associative IP-to-MAC cache.
// An input transfer is written into the queue, the back end then loads its result into the
// registered result stage, and the result transfer completes from there when m_tready is high.
// Throughput: one transfer per cycle while m_tready is high; all cache entries compare in parallel.
// A two-entry queue between front end and back end lets each side stall on its own.
// Reset (aresetn low, synchronous) empties the queue, the result stage and the cache,
// and clears my_ip and the replacement pointer.
`timescale 1ns / 1ps
`default_nettype none
module arp_responder_with_cache_top #(
    parameter int CACHE_ENTRIES = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Configuration write port. Index 0 is my_ip, index 1 is my_mac.
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [47:0]  cfg_wdata,
    // Input stream.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata from bit 0 up: hw_type, proto_type, hw_len, proto_len, operation,
    // snd_mac, snd_ip, tgt_ip, query_ip.
    input  wire logic [207:0] s_tdata,
    // tuser: action (0 received packet, 1 resolve query).
    input  wire logic         s_tuser,
    // Result stream.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata from bit 0 up: reply_dest_mac, reply_dest_ip, resolved_mac.
    output logic [127:0]      m_tdata,
    // tuser: status.
    output logic [2:0]        m_tuser
);

    // Only my_ip affects the results. The source MAC of a reply is not part of the
    // result transfer, so a write to my_mac has no visible effect and is not kept.
    logic [31:0] my_ip_reg, my_ip_next;

    logic                  push, pop;
    arpc_pkg::item_t       push_item, head_item;
    arpc_pkg::queue_stat_t q_stat;

    always_comb begin
        my_ip_next = my_ip_reg;
        if (cfg_we && (cfg_index == arpc_pkg::REG_MY_IP)) begin
            my_ip_next = cfg_wdata[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            my_ip_reg <= '0;
        end else begin
            my_ip_reg <= my_ip_next;
        end
    end

    // The front end decodes the packet and decides everything that does not need
    // the cache: header checks, operation decode and the match on our own address.
    arpc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .my_ip    (my_ip_reg),
        .q_stat   (q_stat),
        .push     (push),
        .item     (push_item)
    );

    arpc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_stat    (q_stat)
    );

    // The back end owns the cache. Items leave the queue in order, so a query
    // always sees every insert made by earlier transfers.
    arpc_back #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_stat    (q_stat),
        .head_item (head_item),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // The queue can never be empty and full at once.
    a_queue_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.empty && q_stat.full))
        else $error("queue reports empty and full together");

    // Only a resolve hit carries a resolved MAC.
    a_res_mac_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != arpc_pkg::ST_HIT)) |-> (m_tdata[127:80] == 48'd0))
        else $error("resolved MAC set on a result that is not a hit");

    // Only a sent reply carries destination fields.
    a_dest_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != arpc_pkg::ST_REPLY)) |-> (m_tdata[79:0] == 80'd0))
        else $error("reply destination set on a result that is not a reply");

    // A transfer into an empty queue with a free result stage passes the queue, then the result stage.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && q_stat.empty && (!m_tvalid || m_tready)) |=> ##1 m_tvalid)
        else $error("result missing two cycles after input transfer");

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the ARP responder with its IP-to-MAC cache.
`timescale 1ns / 1ps
module testbench;

    localparam int CACHE_DEPTH  = 16;
    // More learned addresses than cache entries, so the cache fills and entries are replaced.
    localparam int POOL_SIZE    = 24;
    localparam int PHASE_ITEMS  = 250;
    // Length of the long receiver hold-off that backs up the block.
    localparam int HOLD_CYCLES  = 300;
    // Idle cycles let pass before configuration writes and before the final verdict.
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    // One parsed ARP packet or resolve query, as the sender presents it.
    typedef struct packed {
        logic        action;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] operation;
        logic [47:0] snd_mac;
        logic [31:0] snd_ip;
        logic [31:0] tgt_ip;
        logic [31:0] query_ip;
    } arp_item_t;

    // One result of the block, field by field.
    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] dest_mac;
        logic [31:0] dest_ip;
        logic [47:0] res_mac;
    } arp_result_t;

    logic         aclk;
    logic         aresetn   = 1'b0;
    logic         cfg_we    = 1'b0;
    logic         cfg_index = 1'b0;
    logic [47:0]  cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    // Fields from bit 0 up: hw_type, proto_type, hw_len, proto_len, operation,
    // snd_mac, snd_ip, tgt_ip, query_ip.
    logic [207:0] s_tdata   = '0;
    // Field: action.
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    // Fields from bit 0 up: reply_dest_mac, reply_dest_ip, resolved_mac.
    logic [127:0] m_tdata;
    // Field: status.
    logic [2:0]   m_tuser;

    // Items waiting to be offered; the head is the one on the bus while s_tvalid is high.
    arp_item_t   pending_q[$];
    // Results predicted for accepted items, oldest first.
    arp_result_t expected_q[$];

    // Our own copy of the block's configuration and cache.
    logic [31:0] cfg_ip = '0;
    bit          cache_vld [CACHE_DEPTH];
    logic [31:0] cache_ip  [CACHE_DEPTH];
    logic [47:0] cache_mac [CACHE_DEPTH];
    int          repl_ptr = 0;

    logic [31:0] ip_pool [POOL_SIZE];

    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;
    int          hold_trigger = 0;
    int          hold_seen    = 0;
    int          hold_left    = 0;
    int          error_cnt    = 0;
    int          cycle_cnt    = 0;

    arp_responder_with_cache_top #(
        .CACHE_ENTRIES(CACHE_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Index of the valid cache entry holding this IP, or -1 when there is none.
    function automatic int find_entry(input logic [31:0] ip);
        for (int k = 0; k < CACHE_DEPTH; k++) begin
            if (cache_vld[k] && cache_ip[k] == ip) return k;
        end
        return -1;
    endfunction

    // Works out the result of one accepted item and updates the cache copy as the
    // block would. Only valid entries are ever compared or read.
    function automatic arp_result_t predict_arp(input arp_item_t it);
        arp_result_t r;
        int slot;
        r = '0;
        if (it.action == arpc_pkg::ACT_QUERY) begin
            slot = find_entry(it.query_ip);
            if (slot >= 0) begin
                r.status  = arpc_pkg::ST_HIT;
                r.res_mac = cache_mac[slot];
            end else begin
                r.status = arpc_pkg::ST_MISS;
            end
        end else if (it.hw_type != arpc_pkg::HTYPE_ETH || it.proto_type != arpc_pkg::PTYPE_IPV4 ||
                     it.hw_len != arpc_pkg::HLEN_ETH || it.proto_len != arpc_pkg::PLEN_IPV4) begin
            r.status = arpc_pkg::ST_DROPPED;
        end else if (it.operation == arpc_pkg::ARP_OP_REQ) begin
            if (it.tgt_ip == cfg_ip) begin
                r.status   = arpc_pkg::ST_REPLY;
                r.dest_mac = it.snd_mac;
                r.dest_ip  = it.snd_ip;
                // Learn the requester: overwrite a known IP, else take the lowest
                // free entry, else replace round-robin.
                slot = find_entry(it.snd_ip);
                if (slot < 0) begin
                    for (int k = CACHE_DEPTH - 1; k >= 0; k--) begin
                        if (!cache_vld[k]) slot = k;
                    end
                end
                if (slot < 0) begin
                    slot     = repl_ptr;
                    repl_ptr = (repl_ptr + 1) % CACHE_DEPTH;
                end
                cache_vld[slot] = 1'b1;
                cache_ip[slot]  = it.snd_ip;
                cache_mac[slot] = it.snd_mac;
            end else begin
                r.status = arpc_pkg::ST_IGNORED;
            end
        end else if (it.operation == arpc_pkg::ARP_OP_RSP) begin
            r.status = arpc_pkg::ST_IGNORED;
        end else begin
            r.status = arpc_pkg::ST_UNKNOWN_OP;
        end
        return r;
    endfunction

    // A packet with a well-formed header and random addresses.
    function automatic arp_item_t good_packet(input logic [15:0] op);
        arp_item_t it;
        it.action     = arpc_pkg::ACT_PACKET;
        it.hw_type    = arpc_pkg::HTYPE_ETH;
        it.proto_type = arpc_pkg::PTYPE_IPV4;
        it.hw_len     = arpc_pkg::HLEN_ETH;
        it.proto_len  = arpc_pkg::PLEN_IPV4;
        it.operation  = op;
        it.snd_mac    = rand48();
        it.snd_ip     = $urandom;
        it.tgt_ip     = $urandom;
        it.query_ip   = $urandom;
        return it;
    endfunction

    // Random traffic: mostly requests for our address from a small set of senders,
    // so the cache fills, overwrites and replaces, plus queries that mostly hit.
    // The rest covers other targets, replies, unknown operations and bad headers.
    function automatic arp_item_t random_item();
        arp_item_t   it;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            it = good_packet(arpc_pkg::ARP_OP_REQ);
            it.tgt_ip = cfg_ip;
            if ($urandom_range(9) != 0) it.snd_ip = ip_pool[$urandom_range(POOL_SIZE - 1)];
        end else if (pick < 70) begin
            // Packet fields are random on a query; they must have no effect.
            it = good_packet(16'($urandom));
            it.action     = arpc_pkg::ACT_QUERY;
            it.hw_type    = 16'($urandom);
            it.proto_type = 16'($urandom);
            it.hw_len     = 8'($urandom);
            it.proto_len  = 8'($urandom);
            if ($urandom_range(3) != 0) it.query_ip = ip_pool[$urandom_range(POOL_SIZE - 1)];
        end else if (pick < 80) begin
            it = good_packet(arpc_pkg::ARP_OP_REQ);
        end else if (pick < 85) begin
            it = good_packet(arpc_pkg::ARP_OP_RSP);
            if ($urandom_range(1) == 0) it.tgt_ip = cfg_ip;
        end else if (pick < 90) begin
            it = good_packet(16'($urandom));
            it.tgt_ip = cfg_ip;
        end else begin
            it = good_packet(16'($urandom_range(3)));
            it.tgt_ip = cfg_ip;
            case ($urandom_range(4))
                0: it.hw_type    = 16'($urandom);
                1: it.proto_type = 16'($urandom);
                2: it.hw_len     = 8'($urandom);
                3: it.proto_len  = 8'($urandom);
                default: begin
                    it.hw_type    = 16'($urandom);
                    it.proto_type = 16'($urandom);
                    it.hw_len     = 8'($urandom);
                    it.proto_len  = 8'($urandom);
                end
            endcase
        end
        return it;
    endfunction

    // Issues one register write. The model copy is updated at once, since writes
    // happen only while nothing is in flight.
    task automatic set_reg(input logic idx, input logic [47:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        if (idx == arpc_pkg::REG_MY_IP) cfg_ip = data[31:0];
    endtask

    // Waits until every item is sent and every result has arrived, then lets the
    // pipeline settle.
    task automatic wait_idle();
        do @(posedge aclk); while (pending_q.size() != 0 || expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_cnt++;
        end
    endtask

    // Driver. The head of the pending queue stays on the bus until the transfer
    // completes; at that edge the accepted item is predicted and removed. A new
    // item is offered unless the random sender idle roll says otherwise.
    always @(posedge aclk) begin : driver
        arp_item_t next_item;
        logic      busy;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            busy = s_tvalid && !s_tready;
            if (s_tvalid && s_tready) begin
                expected_q.push_back(predict_arp(pending_q.pop_front()));
            end
            if (!busy) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    next_item = pending_q[0];
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_item.action;
                    s_tdata  <= {next_item.query_ip, next_item.tgt_ip, next_item.snd_ip,
                                 next_item.snd_mac, next_item.operation,
                                 next_item.proto_len, next_item.hw_len,
                                 next_item.proto_type, next_item.hw_type};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver. A change of hold_trigger starts a long hold-off counted here;
    // otherwise tready follows the random stall rate of the phase.
    always @(posedge aclk) begin : receiver
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor. Every result transfer is compared with the oldest prediction.
    always @(posedge aclk) begin : monitor
        arp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d data %h",
                         $time, m_tuser, m_tdata);
                error_cnt++;
            end else begin
                want = expected_q.pop_front();
                check_field("status", 48'(want.status), 48'(m_tuser));
                check_field("reply_dest_mac", want.dest_mac, m_tdata[47:0]);
                check_field("reply_dest_ip", 48'(want.dest_ip), 48'(m_tdata[79:48]));
                check_field("resolved_mac", want.res_mac, m_tdata[127:80]);
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Stimulus sequence: reset, a directed part, then five random phases, each
    // with its own register settings and handshake pressure.
    initial begin : main
        arp_item_t it;
        logic [31:0] ip_val;
        logic [47:0] mac_val;

        foreach (ip_pool[k]) ip_pool[k] = $urandom;
        ip_pool[0] = '0;
        ip_pool[1] = '1;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // The upper bits of the IP write are junk; the block must keep only 32 bits.
        set_reg(arpc_pkg::REG_MY_IP, {16'($urandom), 32'($urandom)});
        set_reg(arpc_pkg::REG_MY_MAC, rand48());
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);

        // Requests that learn the lowest and highest addresses, then overwrite one.
        it = good_packet(arpc_pkg::ARP_OP_REQ);
        it.tgt_ip  = cfg_ip;
        it.snd_mac = '0;
        it.snd_ip  = '0;
        pending_q.push_back(it);
        it = good_packet(arpc_pkg::ARP_OP_REQ);
        it.tgt_ip  = cfg_ip;
        it.snd_mac = '1;
        it.snd_ip  = '1;
        pending_q.push_back(it);
        it = good_packet(arpc_pkg::ARP_OP_REQ);
        it.tgt_ip = cfg_ip;
        it.snd_ip = '0;
        pending_q.push_back(it);
        // A request for some other IP leaves the cache alone.
        it = good_packet(arpc_pkg::ARP_OP_REQ);
        it.tgt_ip = ~cfg_ip;
        pending_q.push_back(it);
        it = good_packet(arpc_pkg::ARP_OP_RSP);
        it.tgt_ip = cfg_ip;
        pending_q.push_back(it);
        // Unknown operations, both ends of the range and next to the known ones.
        it = good_packet(16'h0000);
        pending_q.push_back(it);
        it = good_packet(16'h0003);
        pending_q.push_back(it);
        it = good_packet(16'hFFFF);
        pending_q.push_back(it);
        // Each header field wrong at its low and high extreme.
        for (int v = 0; v < 8; v++) begin
            it = good_packet(arpc_pkg::ARP_OP_REQ);
            it.tgt_ip = cfg_ip;
            case (v)
                0: it.hw_type    = '0;
                1: it.hw_type    = '1;
                2: it.proto_type = '0;
                3: it.proto_type = '1;
                4: it.hw_len     = '0;
                5: it.hw_len     = '1;
                6: it.proto_len  = '0;
                default: it.proto_len = '1;
            endcase
            pending_q.push_back(it);
        end
        // Queries: the overwritten entry, the all-ones entry, and likely misses.
        it = '1;
        it.action   = arpc_pkg::ACT_QUERY;
        it.query_ip = '0;
        pending_q.push_back(it);
        it = '0;
        it.action   = arpc_pkg::ACT_QUERY;
        it.query_ip = '1;
        pending_q.push_back(it);
        it = good_packet(arpc_pkg::ARP_OP_REQ);
        it.action = arpc_pkg::ACT_QUERY;
        pending_q.push_back(it);
        it = '0;
        it.action   = arpc_pkg::ACT_QUERY;
        it.query_ip = 32'h0000_0001;
        pending_q.push_back(it);
        // Whole packets of zeros and of ones are both malformed.
        it = '0;
        pending_q.push_back(it);
        it = '1;
        it.action = arpc_pkg::ACT_PACKET;
        pending_q.push_back(it);

        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    ip_val  = '0;
                    mac_val = '1;
                end
                1: begin
                    ip_val  = '1;
                    mac_val = '0;
                end
                default: begin
                    // Often reuse a learned address as our own, so it shows up on both sides.
                    ip_val  = ($urandom_range(1) == 0) ? ip_pool[$urandom_range(POOL_SIZE - 1)]
                                                       : 32'($urandom);
                    mac_val = rand48();
                end
            endcase
            set_reg(arpc_pkg::REG_MY_IP, {16'($urandom), ip_val});
            set_reg(arpc_pkg::REG_MY_MAC, mac_val);
            @(posedge aclk);
            cfg_we <= 1'b0;
            @(negedge aclk);
            case (ph)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1: begin
                    sender_idle_pct = 55;
                    recv_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 55;
                end
                3: begin
                    sender_idle_pct = 7;
                    recv_stall_pct  = 7;
                end
                default: begin
                    // Full-rate sender against a receiver that holds off for a long
                    // stretch, so the block backs up and drops s_tready.
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                    hold_trigger++;
                end
            endcase
            repeat (PHASE_ITEMS) pending_q.push_back(random_item());
        end

        wait_idle();
        if (error_cnt == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
